[hw/rtl/lzbr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzbr_pkg
// Shared types and constants of the back-reference / run / fill depacker.
// ----------------------------------------------------------------------------
package lzbr_pkg;

    // History ring
    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    // Field and counter widths
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 17;
    localparam int LEN_W       = 7;
    localparam int MAX_W       = 16;
    localparam int OFF_W       = 12;
    localparam int BV_W        = 2;
    localparam int ST_W        = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * BYTE_W - BV_W - ST_W;

    localparam logic [MAX_W-1:0] MAX_OUTPUT_RST = 16'hC000;
    localparam logic [LEN_W-1:0] LEN_BIAS       = 7'd3;

    localparam logic [BV_W-1:0] BV_NONE = 2'd0;
    localparam logic [BV_W-1:0] BV_ONE  = 2'd1;
    localparam logic [BV_W-1:0] BV_TWO  = 2'd2;

    typedef enum logic [1:0] {
        PH_TOKEN,
        PH_OFFSET,
        PH_LITERAL,
        PH_FILL
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUNNING,
        ST_DONE_OK,
        ST_BAD_REF,
        ST_TRUNCATED
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_LITERAL,
        ACT_FILL,
        ACT_COPY
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PREFETCH,
        S_EMIT,
        S_EMPTY
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic commit;
        logic prefetch;
        logic step;
        logic empty_push;
    } lzbr_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        act_t act;
        logic last_byte;
        logic push_need;
        logic out_free;
    } lzbr_sts_t;

endpackage

[hw/rtl/lzbr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzbr_ctrl
// Sequencer: accept, decode, optional history prefetch, byte emission or empty transfer.
// ----------------------------------------------------------------------------
module lzbr_ctrl
    import lzbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lzbr_sts_t sts,
    output lzbr_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.act)
                    ACT_NONE: state_next = S_EMPTY;
                    ACT_COPY: state_next = S_PREFETCH;
                    default:  state_next = S_EMIT;
                endcase
            end
            S_PREFETCH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if ((!sts.push_need || sts.out_free) && sts.last_byte)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DECODE:
            begin
                cmd.commit = 1'b1;
            end
            S_PREFETCH:
            begin
                cmd.prefetch = 1'b1;
            end
            S_EMIT:
            begin
                // stall only when this byte completes a result and the output is full
                cmd.step = !sts.push_need || sts.out_free;
            end
            S_EMPTY:
            begin
                cmd.empty_push = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/lzbr_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzbr_datapath
// Token decode, stream state, history ring, pair packing and output register.
// ----------------------------------------------------------------------------
module lzbr_datapath
    import lzbr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lzbr_cmd_t              cmd,
    output lzbr_sts_t              sts,
    input  logic [BYTE_W-1:0]      in_data,
    input  logic                   in_first,
    input  logic                   in_last,
    input  logic [MAX_W-1:0]       max_output,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data,
    output logic                   out_last
);

    // Captured input item
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_first_reg;
    logic              in_last_reg;

    // Stream state
    logic [CNT_W-1:0]   prod_reg;
    phase_t             phase_reg;
    logic [LEN_W-1:0]   plen_reg;
    logic [3:0]         offh_reg;
    status_t            fin_reg;

    // Emission state
    logic [HIST_AW-1:0] wr_ptr_reg;
    logic [LEN_W-1:0]   left_reg;
    logic               half_valid_reg;
    logic [BYTE_W-1:0]  half_reg;
    logic               copy_mode_reg;
    logic               offset_one_reg;
    logic [OFF_W-1:0]   offset_reg;

    // History ring
    logic [BYTE_W-1:0]  hist_mem [HIST_DEPTH];
    logic [BYTE_W-1:0]  hist_rdata_reg;
    logic [HIST_AW-1:0] rd_addr;
    logic               rd_en;

    // Output register
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_first_reg;
    logic [BYTE_W-1:0]  out_second_reg;
    logic [BV_W-1:0]    out_bv_reg;
    logic               out_last_reg;
    logic [ST_W-1:0]    out_status_reg;

    // Decode
    logic [CNT_W-1:0]  eff_prod;
    phase_t            eff_phase;
    logic [LEN_W-1:0]  eff_plen;
    logic [3:0]        eff_offh;
    status_t           eff_fin;
    logic [CNT_W-1:0]  limit;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  prod_new;
    phase_t            phase_new;
    logic [LEN_W-1:0]  plen_new;
    logic [3:0]        offh_new;
    status_t           fin_new;
    act_t              act;
    logic [LEN_W-1:0]  nbytes;

    logic [BYTE_W-1:0] emit_byte;
    logic              push_need;
    logic              out_free;
    logic              push;

    assign offset = {eff_offh, in_byte_reg};
    assign limit  = {1'b0, max_output};

    always_comb
    begin
        eff_prod  = in_first_reg ? '0 : prod_reg;
        eff_phase = in_first_reg ? PH_TOKEN : phase_reg;
        eff_plen  = in_first_reg ? '0 : plen_reg;
        eff_offh  = in_first_reg ? '0 : offh_reg;
        eff_fin   = in_first_reg ? ST_RUNNING : fin_reg;

        phase_new = eff_phase;
        plen_new  = eff_plen;
        offh_new  = eff_offh;
        fin_new   = eff_fin;
        prod_new  = eff_prod;
        act       = ACT_NONE;
        nbytes    = '0;

        if (eff_fin == ST_RUNNING)
        begin
            if (eff_phase == PH_TOKEN && eff_prod >= limit)
            begin
                fin_new = ST_DONE_OK;
            end
            else
            begin
                case (eff_phase)
                    PH_TOKEN:
                    begin
                        if (!in_byte_reg[7])
                        begin
                            plen_new  = LEN_W'(in_byte_reg[7:4]) + LEN_BIAS;
                            offh_new  = in_byte_reg[3:0];
                            phase_new = PH_OFFSET;
                        end
                        else if (!in_byte_reg[6])
                        begin
                            // empty literal run is the end-of-stream marker
                            if (in_byte_reg[5:0] == '0)
                            begin
                                fin_new = ST_DONE_OK;
                            end
                            else
                            begin
                                plen_new  = LEN_W'(in_byte_reg[5:0]);
                                phase_new = PH_LITERAL;
                            end
                        end
                        else
                        begin
                            plen_new  = LEN_W'(in_byte_reg[5:0]) + LEN_BIAS;
                            phase_new = PH_FILL;
                        end
                    end
                    PH_OFFSET:
                    begin
                        phase_new = PH_TOKEN;
                        if (offset == '0 || CNT_W'(offset) > eff_prod)
                        begin
                            fin_new = ST_BAD_REF;
                        end
                        else
                        begin
                            act      = ACT_COPY;
                            nbytes   = eff_plen;
                            plen_new = '0;
                        end
                    end
                    PH_LITERAL:
                    begin
                        act      = ACT_LITERAL;
                        nbytes   = LEN_W'(1);
                        plen_new = (eff_plen == '0) ? '0 : eff_plen - 1'b1;
                        if (plen_new == '0)
                        begin
                            phase_new = PH_TOKEN;
                        end
                    end
                    default:
                    begin
                        act       = ACT_FILL;
                        nbytes    = eff_plen;
                        plen_new  = '0;
                        phase_new = PH_TOKEN;
                    end
                endcase
                prod_new = eff_prod + CNT_W'(nbytes);
                if (fin_new == ST_RUNNING && phase_new == PH_TOKEN && prod_new >= limit)
                begin
                    fin_new = ST_DONE_OK;
                end
                if (fin_new == ST_RUNNING && in_last_reg)
                begin
                    fin_new = (phase_new == PH_TOKEN) ? ST_DONE_OK : ST_TRUNCATED;
                end
            end
        end
    end

    // Capture and commit
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_byte_reg  <= in_data;
            in_first_reg <= in_first;
            in_last_reg  <= in_last;
        end
        if (cmd.commit)
        begin
            copy_mode_reg  <= (act == ACT_COPY);
            offset_one_reg <= (offset == OFF_W'(1));
            offset_reg     <= offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg  <= '0;
            phase_reg <= PH_TOKEN;
            plen_reg  <= '0;
            offh_reg  <= '0;
            fin_reg   <= ST_RUNNING;
        end
        else if (cmd.commit)
        begin
            prod_reg  <= prod_new;
            phase_reg <= phase_new;
            plen_reg  <= plen_new;
            offh_reg  <= offh_new;
            fin_reg   <= fin_new;
        end
    end

    // Byte emission
    assign emit_byte = copy_mode_reg ? hist_rdata_reg : in_byte_reg;
    assign push_need = half_valid_reg || (left_reg == LEN_W'(1));
    assign out_free  = !out_valid_reg || out_ready;
    assign push      = (cmd.step && push_need) || cmd.empty_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            left_reg       <= '0;
            half_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            if (in_first_reg)
            begin
                wr_ptr_reg <= '0;
            end
            left_reg       <= nbytes;
            half_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            wr_ptr_reg     <= wr_ptr_reg + 1'b1;
            left_reg       <= left_reg - 1'b1;
            half_valid_reg <= !push_need;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && !push_need)
        begin
            half_reg <= emit_byte;
        end
    end

    // History: one write and one registered read per cycle. Distance one reuses
    // the prefetched byte; longer distances always read an earlier write.
    assign rd_addr = (cmd.prefetch ? wr_ptr_reg : wr_ptr_reg + 1'b1)
                     - HIST_AW'(offset_reg);
    assign rd_en   = cmd.prefetch || (cmd.step && copy_mode_reg && !offset_one_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            hist_mem[wr_ptr_reg] <= emit_byte;
        end
        if (rd_en)
        begin
            hist_rdata_reg <= hist_mem[rd_addr];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_status_reg <= fin_reg;
            if (cmd.empty_push)
            begin
                out_first_reg  <= '0;
                out_second_reg <= '0;
                out_bv_reg     <= BV_NONE;
                out_last_reg   <= 1'b1;
            end
            else
            begin
                out_last_reg <= (left_reg == LEN_W'(1));
                if (half_valid_reg)
                begin
                    out_first_reg  <= half_reg;
                    out_second_reg <= emit_byte;
                    out_bv_reg     <= BV_TWO;
                end
                else
                begin
                    out_first_reg  <= emit_byte;
                    out_second_reg <= '0;
                    out_bv_reg     <= BV_ONE;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {{OUT_PAD_W{1'b0}}, out_status_reg, out_bv_reg,
                        out_second_reg, out_first_reg};

    assign sts.act       = act;
    assign sts.last_byte = (left_reg == LEN_W'(1));
    assign sts.push_need = push_need;
    assign sts.out_free  = out_free;

`ifndef SYNTHESIS
    // write pointer tracks the byte count whenever no emission is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg == '0) |-> (wr_ptr_reg == prod_reg[HIST_AW-1:0]))
        else $error("history pointer out of step with byte count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && push_need) |-> out_free)
        else $error("result pushed into a full output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        half_valid_reg |-> (left_reg != '0))
        else $error("held byte without a following byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bv_reg == BV_NONE) |-> out_last_reg)
        else $error("empty result not marked as last");
`endif

endmodule

[hw/rtl/lz_backref_rle_depacker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_backref_rle_depacker_unit
// Depacker for back-reference, literal-run and fill tokens, up to two bytes a result.
// ----------------------------------------------------------------------------
// One packed byte is taken per transfer on the slave stream and decoded against
// a 4096-byte history ring. Decoded bytes leave on the master stream up to two
// per transfer, with a byte count and the stream status in every transfer and
// tlast on the final transfer caused by each input byte. A byte that produces no
// output still gives one empty transfer carrying the status. Each input byte is
// captured and decoded; the offset byte that starts a copy then prefetches the
// first history byte, and the decoded bytes, or the empty transfer, are emitted.
// A new input byte is taken only once the previous one is fully emitted. The
// history ring has one write port, so decoded bytes are produced one per clock
// while the master stream accepts them; back-pressure there stalls emission.
// No clearing pass follows reset.
// max_output is written through the cfg channel, which is always ready; write it
// only between streams.
// ----------------------------------------------------------------------------
module lz_backref_rle_depacker_unit
    import lzbr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] packed_byte
    input  logic                   s_axis_tuser,   // [0] first_of_stream
    input  logic                   s_axis_tlast,   // last_of_stream

    // Output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] data_first, [15:8] data_second,
                                                   // [17:16] bytes_valid, [19:18] status
    output logic                   m_axis_tlast,   // run_end

    // Configuration: max_output
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [MAX_W-1:0]       cfg_data
);

    logic [MAX_W-1:0] max_output_reg;
    lzbr_cmd_t        cmd;
    lzbr_sts_t        sts;

    // Hold the output limit; a transfer on cfg replaces it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_output_reg <= MAX_OUTPUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_output_reg <= cfg_data;
        end
    end

    lzbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lzbr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_data    (s_axis_tdata),
        .in_first   (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .max_output (max_output_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule
